// ----- sv/stsf_pkg.sv -----
// stsf_pkg: shared types, constants and colour snap functions for the toon-shade filter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package stsf_pkg;
    localparam int MaxWidth   = 256;
    localparam int ColW       = 8;
    localparam int SlotW      = 9;
    localparam int PixW       = 12;

    localparam logic [11:0] ThreshReset = 12'd3000;
    localparam logic [8:0]  WidthReset  = 9'd256;

    localparam logic [0:0] RegThreshold = 1'b0;
    localparam logic [0:0] RegWidth     = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SQRT,
        ST_OUT
    } state_t;

    function automatic logic [11:0] snap5(input logic [11:0] v);
        logic [11:0] r;
        begin
            if (v == 12'd0)         r = 12'd0;
            else if (v <= 12'd820)  r = 12'd820;
            else if (v <= 12'd1640) r = 12'd1640;
            else if (v <= 12'd2458) r = 12'd2458;
            else if (v <= 12'd3278) r = 12'd3278;
            else                    r = 12'd4095;
            return r;
        end
    endfunction

    function automatic logic [11:0] snap4(input logic [11:0] v);
        logic [11:0] r;
        begin
            if (v == 12'd0)         r = 12'd0;
            else if (v <= 12'd1000) r = 12'd1000;
            else if (v <= 12'd2000) r = 12'd2000;
            else if (v <= 12'd3000) r = 12'd3000;
            else                    r = 12'd4095;
            return r;
        end
    endfunction
endpackage
`default_nettype wire

// ----- sv/sobel_toon_shade_filter.sv -----
// sobel_toon_shade_filter: top level, line stores in memory, Sobel, sqrt, shading.
// Depends on stsf_pkg.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//  s_axis carries one pixel request per transfer; tuser = {frame_start, kind}
//  (kind in bit 0: 1 = flush pad), tdata = {blue,green,red}, red from bit 0 up.
//  m_axis returns the shaded pixel of the center one row above and one column
//  left; tdata = {is_edge,blue,green,red}. The first frame_width + 1 requests
//  of a frame give no result; later ones give one each.
//  A request with a result goes from its accept through the memory read and
//  gradient state, the two-step-per-cycle square root and the load of the
//  output register before the next accept; its result is valid once that
//  register is loaded. A request without a result returns to idle after
//  the read state. The square-root loop sets the rate.
//  A result sits in the output register while m_axis_tready is low; one more
//  request is accepted and computed, then waits in the hand-over state with
//  s_axis_tready low until the register frees.
//  Config: cfg_we/cfg_index/cfg_data, 0 = edge threshold, 1 = frame width;
//  the user must see they are written only while idle, the block does not enforce this.
//  Reset clears counters, window and control; line memories are not cleared
//  (never-written entries read as don't-care).
module sobel_toon_shade_filter
    import stsf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // red, green, blue, zero pad
    input  wire logic [1:0]  s_axis_tuser,   // kind, frame_start
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // red, green, blue, is_edge, pad
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [11:0] cfg_data
);
    logic [11:0] thresh_reg;
    logic [8:0]  width_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= ThreshReset;
            width_reg  <= WidthReset;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                RegThreshold: thresh_reg <= cfg_data;
                RegWidth:     width_reg  <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    logic [8:0] w;
    always_comb
    begin
        if (width_reg < 9'd3) w = 9'd3;
        else if (width_reg > 9'd256) w = 9'd256;
        else w = width_reg;
    end

    state_t state_reg, state_next;
    logic [8:0]  col_reg;     // holds up to 255
    logic [15:0] row_reg;
    logic [8:0]  slot_reg;
    logic [11:0] win_reg [6];
    logic [3:0]  it_reg;
    logic        acc;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign acc = s_axis_tvalid && s_axis_tready;

    // captured request
    logic [11:0] r_reg, g_reg, b_reg;
    logic [8:0]  c_reg;
    logic [15:0] rw_reg;
    logic [8:0]  sl_reg;

    // start-of-request column/row/slot after frame start and wrap
    logic [8:0]  c0, sl0;
    logic [15:0] r0;
    always_comb
    begin
        c0  = s_axis_tuser[1] ? 9'd0 : col_reg;
        r0  = s_axis_tuser[1] ? 16'd0 : row_reg;
        sl0 = s_axis_tuser[1] ? 9'd0 : slot_reg;
        if (c0 >= w)
        begin
            c0 = 9'd0;
            if (r0 != 16'hFFFF) r0 = r0 + 16'd1;
        end
        if (sl0 > w) sl0 = 9'd0;
    end

    // memories
    logic [23:0] line_mem [MaxWidth];   // {two_above, above}
    logic [35:0] rgb_mem [MaxWidth + 1];
    logic [23:0] line_q;
    logic [35:0] rgb_q;
    logic        wr_en;

    logic [21:0] grey_sum;
    assign grey_sum = 22'(r_reg) * 22'd307 + 22'(g_reg) * 22'd604 + 22'(b_reg) * 22'd113;

    // window and gradient, formed in ST_READ
    logic [11:0] up1, up2, gr;
    logic [11:0] lt [3], md [3], rt [3];
    logic signed [15:0] gx, gy;
    logic signed [31:0] gx_w, gy_w;
    logic [31:0] sq;
    always_comb
    begin
        gr  = grey_sum[21:10];
        up1 = (rw_reg >= 16'd1) ? line_q[11:0] : 12'd0;
        up2 = (rw_reg >= 16'd2) ? line_q[23:12] : 12'd0;
        for (int i = 0; i < 3; i++)
        begin
            lt[i] = (c_reg == 9'd1) ? 12'd0 : win_reg[i];
            md[i] = win_reg[3+i];
        end
        rt[0] = (c_reg == 9'd0) ? 12'd0 : up2;
        rt[1] = (c_reg == 9'd0) ? 12'd0 : up1;
        rt[2] = (c_reg == 9'd0) ? 12'd0 : gr;
        gx = 16'(rt[0]) + 16'({rt[1], 1'b0}) + 16'(rt[2])
           - 16'(lt[0]) - 16'({lt[1], 1'b0}) - 16'(lt[2]);
        gy = 16'(lt[0]) + 16'({md[0], 1'b0}) + 16'(rt[0])
           - 16'(lt[2]) - 16'({md[2], 1'b0}) - 16'(rt[2]);
        gx_w = 32'(gx);
        gy_w = 32'(gy);
        sq = 32'(gx_w * gx_w + gy_w * gy_w);
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            line_q <= line_mem[c0[ColW-1:0]];
            rgb_q  <= rgb_mem[sl0];
        end
        if (wr_en)
        begin
            line_mem[c_reg[ColW-1:0]] <= {line_q[11:0], gr};
            rgb_mem[sl_reg] <= {b_reg, g_reg, r_reg};
        end
    end

    // square root, two 2-bit steps per cycle, 16 steps in all
    logic [31:0] v_reg, res_reg, bit_reg;
    logic [31:0] v1, res1, b1, v2, res2, b2;
    always_comb
    begin
        v1 = v_reg; res1 = res_reg; b1 = bit_reg;
        if (v1 >= res1 + b1) begin v1 = v1 - (res1 + b1); res1 = (res1 >> 1) + b1; end
        else res1 = res1 >> 1;
        b1 = b1 >> 2;
        v2 = v1; res2 = res1; b2 = b1;
        if (v2 >= res2 + b2) begin v2 = v2 - (res2 + b2); res2 = (res2 >> 1) + b2; end
        else res2 = res2 >> 1;
        b2 = b2 >> 2;
    end

    function automatic logic emit_reg_n();
        return (rw_reg >= 16'd2) || (rw_reg == 16'd1 && c_reg >= 9'd1);
    endfunction

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (acc) state_next = ST_READ;
            ST_READ: state_next = emit_reg_n() ? ST_SQRT : ST_IDLE;
            ST_SQRT: if (it_reg == 4'd7) state_next = ST_OUT;
            ST_OUT:  if (!m_axis_tvalid || m_axis_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        wr_en = (state_reg == ST_READ);
    end

    logic [11:0] mag;
    assign mag = (res_reg > 32'd4095) ? 12'd4095 : res_reg[11:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            col_reg <= '0; row_reg <= '0; slot_reg <= '0;
            for (int i = 0; i < 6; i++) win_reg[i] <= '0;
            it_reg <= '0;
            m_axis_tvalid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // in ST_OUT the register is reloaded whenever it drains
            if (state_reg != ST_OUT && m_axis_tvalid && m_axis_tready)
                m_axis_tvalid <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (acc)
                    begin
                        r_reg  <= s_axis_tuser[0] ? 12'd0 : s_axis_tdata[11:0];
                        g_reg  <= s_axis_tuser[0] ? 12'd0 : s_axis_tdata[23:12];
                        b_reg  <= s_axis_tuser[0] ? 12'd0 : s_axis_tdata[35:24];
                        c_reg  <= c0; rw_reg <= r0; sl_reg <= sl0;
                    end
                end
                ST_READ:
                begin
                    v_reg <= sq; res_reg <= '0; bit_reg <= 32'h4000_0000;
                    it_reg <= '0;
                    for (int i = 0; i < 3; i++)
                    begin
                        win_reg[i] <= win_reg[3+i];
                    end
                    win_reg[3] <= up2; win_reg[4] <= up1; win_reg[5] <= gr;
                    slot_reg <= (sl_reg + 9'd1 > w) ? 9'd0 : sl_reg + 9'd1;
                    if (c_reg + 9'd1 >= w)
                    begin
                        col_reg <= 9'd0;
                        row_reg <= (rw_reg != 16'hFFFF) ? rw_reg + 16'd1 : rw_reg;
                    end
                    else
                    begin
                        col_reg <= c_reg + 9'd1;
                        row_reg <= rw_reg;
                    end
                end
                ST_SQRT:
                begin
                    v_reg <= v2; res_reg <= res2; bit_reg <= b2;
                    if (it_reg == 4'd7) it_reg <= '0;
                    else it_reg <= it_reg + 4'd1;
                end
                ST_OUT:
                begin
                    if (!m_axis_tvalid || m_axis_tready)
                    begin
                        m_axis_tvalid <= 1'b1;
                        if (mag > thresh_reg)
                            m_axis_tdata <= {3'b0, 1'b1, 12'd4095 - mag,
                                             12'd4095 - mag, 12'd4095 - mag};
                        else
                            m_axis_tdata <= {3'b0, 1'b0, snap5(rgb_q[35:24]),
                                             snap4(rgb_q[23:12]), snap5(rgb_q[11:0])};
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- sv/stsf_checker.sv -----
// stsf_checker: port-level checks for sobel_toon_shade_filter, with bind.
// Depends on sobel_toon_shade_filter through the bind; uses nothing from stsf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module stsf_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped under stall");
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[39:37] == 3'b0)
        else $error("pad bits set");
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("back-to-back accept");
endmodule

bind sobel_toon_shade_filter stsf_checker u_chk (.*);
`default_nettype wire
